[hw/rtl/radf_pkg.sv]
// Shared types, widths and codes of the radial direction block.
`timescale 1ns / 1ps
package radf_pkg;

   localparam int CW = 24;                  // point and origin coordinates
   localparam int NW = 16;                  // normal and axis components
   localparam int DW = 16;                  // output direction components
   localparam int RW = 60;                  // exact radial vector, signed
   localparam int MW = 59;                  // radial magnitude
   localparam int PW = 6;                   // bit position within MW
   localparam int NMW = 30;                 // normalized magnitude
   localparam int NORM_MSB = 29;            // top bit of a normalized maximum
   localparam int XW = 63;                  // square root working width
   localparam int ROOTW = 31;               // square root result bits
   localparam int OUT_FRAC_BITS_DEF = 14;

   // A normal must have squared length above (0.5 in Q.12)^2.
   localparam logic [31:0] NRM_MIN_SQ = 32'd1 << 22;

   typedef enum logic [1:0] {
      SRC_RADIAL = 2'd0,
      SRC_NORMAL = 2'd1,
      SRC_NONE   = 2'd2
   } src_type;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_AXIS_X   = 3'd3,
      CSR_AXIS_Y   = 3'd4,
      CSR_AXIS_Z   = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [2:0][CW-1:0] pt;
      logic [2:0][NW-1:0] nrm;
      logic               np;
   } item_type;

   typedef struct packed {
      logic [2:0][CW-1:0] origin;
      logic [2:0][NW-1:0] axis;
   } cfg_type;

   typedef struct packed {
      logic [2:0][MW-1:0] mag;
      logic [2:0]         neg;
      src_type            src;
   } vsel_type;

   typedef struct packed {
      logic [2:0][NMW-1:0] mag;
      logic [2:0]          neg;
      src_type             src;
   } nvec_type;

endpackage

[hw/rtl/radf_if.sv]
// Request and response channel interfaces of the radial direction block.
`timescale 1ns / 1ps
interface radf_req_if;
   logic                           valid;
   logic                           ready;
   logic signed [radf_pkg::CW-1:0] point_x;
   logic signed [radf_pkg::CW-1:0] point_y;
   logic signed [radf_pkg::CW-1:0] point_z;
   logic signed [radf_pkg::NW-1:0] surf_normal_x;
   logic signed [radf_pkg::NW-1:0] surf_normal_y;
   logic signed [radf_pkg::NW-1:0] surf_normal_z;
   logic                           normal_present;

   modport source(output valid, point_x, point_y, point_z, surf_normal_x, surf_normal_y,
                  surf_normal_z, normal_present, input ready);
   modport sink(input valid, point_x, point_y, point_z, surf_normal_x, surf_normal_y,
                surf_normal_z, normal_present, output ready);
endinterface

interface radf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [radf_pkg::DW-1:0] dir_x;
   logic signed [radf_pkg::DW-1:0] dir_y;
   logic signed [radf_pkg::DW-1:0] dir_z;
   logic [1:0]                     dir_source;

   modport source(output valid, dir_x, dir_y, dir_z, dir_source, input ready);
   modport sink(input valid, dir_x, dir_y, dir_z, dir_source, output ready);
endinterface

[hw/rtl/radf_front.sv]
// Exact radial vector R = d*A2 - (d.a)*a and source selection, six stages.
`timescale 1ns / 1ps
module radf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  radf_pkg::item_type in_item,
   input  radf_pkg::cfg_type  cfg,
   output logic               out_valid,
   output radf_pkg::vsel_type out_vec
);

   logic [5:0] v_ff;

   // stage 1: offsets, effective axis, squared lengths
   logic               az;
   logic signed [24:0] d_in [3];
   logic signed [15:0] a_in [3];
   logic signed [31:0] asq [3];
   logic signed [31:0] nsq [3];
   logic [31:0]        a2_in;
   logic [31:0]        n2_in;
   logic signed [24:0] d1_ff [3];
   logic signed [15:0] a1_ff [3];
   logic [31:0]        a21_ff;
   logic               nok1_ff;
   logic [2:0][15:0]   n1_ff;

   always_comb begin
      az = (cfg.axis == '0);
      for (int k = 0; k < 3; k++) begin
         d_in[k] = $signed({in_item.pt[k][radf_pkg::CW-1], in_item.pt[k]})
                 - $signed({cfg.origin[k][radf_pkg::CW-1], cfg.origin[k]});
         a_in[k] = az ? ((k == 0) ? 16'sd1 : 16'sd0) : $signed(cfg.axis[k]);
         asq[k]  = a_in[k] * a_in[k];
         nsq[k]  = $signed(in_item.nrm[k]) * $signed(in_item.nrm[k]);
      end
      a2_in = 32'(asq[0]) + 32'(asq[1]) + 32'(asq[2]);
      n2_in = 32'(nsq[0]) + 32'(nsq[1]) + 32'(nsq[2]);
   end

   // stage 2: products
   logic signed [40:0] pa_in [3];
   logic signed [57:0] pb_in [3];
   logic signed [40:0] pa2_ff [3];
   logic signed [57:0] pb2_ff [3];
   logic signed [15:0] a2_ff [3];
   logic               nok2_ff;
   logic [2:0][15:0]   n2_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pa_in[k] = 41'(d1_ff[k]) * 41'(a1_ff[k]);
         pb_in[k] = 58'(d1_ff[k]) * 58'($signed({1'b0, a21_ff}));
      end
   end

   // stage 3: dot product
   logic signed [42:0] dot_in;
   logic signed [42:0] dot3_ff;
   logic signed [57:0] pb3_ff [3];
   logic signed [15:0] a3_ff [3];
   logic               nok3_ff;
   logic [2:0][15:0]   n3_ff;

   assign dot_in = 43'(pa2_ff[0]) + 43'(pa2_ff[1]) + 43'(pa2_ff[2]);

   // stage 4: axial part
   logic signed [58:0] pc_in [3];
   logic signed [58:0] pc4_ff [3];
   logic signed [57:0] pb4_ff [3];
   logic               nok4_ff;
   logic [2:0][15:0]   n4_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pc_in[k] = 59'(dot3_ff) * 59'(a3_ff[k]);
      end
   end

   // stage 5: radial vector
   logic signed [radf_pkg::RW-1:0] r_in [3];
   logic signed [radf_pkg::RW-1:0] r5_ff [3];
   logic                           nok5_ff;
   logic [2:0][15:0]               n5_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         r_in[k] = radf_pkg::RW'(pb4_ff[k]) - radf_pkg::RW'(pc4_ff[k]);
      end
   end

   // stage 6: pick radial, normal or nothing
   logic                           rz;
   logic signed [radf_pkg::RW-1:0] rneg;
   logic signed [16:0]             nabs;
   radf_pkg::vsel_type             sel_in;
   radf_pkg::vsel_type             sel_ff;

   always_comb begin
      rz     = (r5_ff[0] == '0) && (r5_ff[1] == '0) && (r5_ff[2] == '0);
      sel_in = '0;
      rneg   = '0;
      nabs   = '0;
      if (!rz) begin
         sel_in.src = radf_pkg::SRC_RADIAL;
      end else if (nok5_ff) begin
         sel_in.src = radf_pkg::SRC_NORMAL;
      end else begin
         sel_in.src = radf_pkg::SRC_NONE;
      end
      for (int k = 0; k < 3; k++) begin
         rneg = -r5_ff[k];
         nabs = n5_ff[k][15] ? -17'($signed(n5_ff[k])) : 17'($signed(n5_ff[k]));
         if (!rz) begin
            sel_in.neg[k] = r5_ff[k][radf_pkg::RW-1];
            sel_in.mag[k] = r5_ff[k][radf_pkg::RW-1] ? rneg[radf_pkg::MW-1:0]
                                                      : r5_ff[k][radf_pkg::MW-1:0];
         end else if (nok5_ff) begin
            sel_in.neg[k] = n5_ff[k][15];
            sel_in.mag[k] = radf_pkg::MW'(unsigned'(nabs));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            d1_ff[k]  <= d_in[k];
            a1_ff[k]  <= a_in[k];
            pa2_ff[k] <= pa_in[k];
            pb2_ff[k] <= pb_in[k];
            a2_ff[k]  <= a1_ff[k];
            pb3_ff[k] <= pb2_ff[k];
            a3_ff[k]  <= a2_ff[k];
            pc4_ff[k] <= pc_in[k];
            pb4_ff[k] <= pb3_ff[k];
            r5_ff[k]  <= r_in[k];
         end
         a21_ff  <= a2_in;
         nok1_ff <= in_item.np && (n2_in > radf_pkg::NRM_MIN_SQ);
         n1_ff   <= in_item.nrm;
         nok2_ff <= nok1_ff;
         n2_ff   <= n1_ff;
         dot3_ff <= dot_in;
         nok3_ff <= nok2_ff;
         n3_ff   <= n2_ff;
         nok4_ff <= nok3_ff;
         n4_ff   <= n3_ff;
         nok5_ff <= nok4_ff;
         n5_ff   <= n4_ff;
         sel_ff  <= sel_in;
      end
   end

   assign out_valid = v_ff[5];
   assign out_vec   = sel_ff;

endmodule

[hw/rtl/radf_norm.sv]
// Block normalization, sum of squares and a one-bit-per-stage square root.
`timescale 1ns / 1ps
module radf_norm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  radf_pkg::vsel_type            in_vec,
   output logic                          out_valid,
   output radf_pkg::nvec_type            out_vec,
   output logic [radf_pkg::ROOTW-1:0]    out_len
);

   localparam int XW = radf_pkg::XW;
   localparam int ROOTW = radf_pkg::ROOTW;

   logic [3:0] v_ff;

   // stage 1: leading one of the largest magnitude
   logic [radf_pkg::MW-1:0] orv;
   logic [radf_pkg::PW-1:0] pos_in;
   logic [radf_pkg::PW-1:0] pos1_ff;
   radf_pkg::vsel_type      vec1_ff;

   always_comb begin
      orv    = in_vec.mag[0] | in_vec.mag[1] | in_vec.mag[2];
      pos_in = '0;
      for (int i = 0; i < radf_pkg::MW; i++) begin
         if (orv[i]) pos_in = radf_pkg::PW'(i);
      end
   end

   // stage 2: shift so the top bit lands at NORM_MSB
   localparam logic [radf_pkg::PW-1:0] TOP = radf_pkg::PW'(radf_pkg::NORM_MSB);
   logic [radf_pkg::MW-1:0] shv [3];
   radf_pkg::nvec_type      nv_in;
   radf_pkg::nvec_type      vec2_ff;

   always_comb begin
      nv_in.neg = vec1_ff.neg;
      nv_in.src = vec1_ff.src;
      for (int k = 0; k < 3; k++) begin
         shv[k] = (pos1_ff >= TOP) ? (vec1_ff.mag[k] >> (pos1_ff - TOP))
                                   : (vec1_ff.mag[k] << (TOP - pos1_ff));
         nv_in.mag[k] = shv[k][radf_pkg::NMW-1:0];
      end
   end

   // stage 3: squares; stage 4: sum
   logic [2*radf_pkg::NMW-1:0] sq3_ff [3];
   radf_pkg::nvec_type         vec3_ff;
   logic [XW-1:0]              s4_ff;
   radf_pkg::nvec_type         vec4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos1_ff <= pos_in;
         vec1_ff <= in_vec;
         vec2_ff <= nv_in;
         for (int k = 0; k < 3; k++) begin
            sq3_ff[k] <= (2*radf_pkg::NMW)'(vec2_ff.mag[k]) * (2*radf_pkg::NMW)'(vec2_ff.mag[k]);
         end
         vec3_ff <= vec2_ff;
         s4_ff   <= XW'(sq3_ff[0]) + XW'(sq3_ff[1]) + XW'(sq3_ff[2]);
         vec4_ff <= vec3_ff;
      end
   end

   // square root: one result bit per stage, trial bit 4^(ROOTW-j) at stage j
   logic [XW-1:0]      x_q   [ROOTW+1];
   logic [XW-1:0]      r_q   [ROOTW+1];
   logic               val_q [ROOTW+1];
   radf_pkg::nvec_type vec_q [ROOTW+1];

   assign x_q[0]   = s4_ff;
   assign r_q[0]   = '0;
   assign val_q[0] = v_ff[3];
   assign vec_q[0] = vec4_ff;

   for (genvar j = 1; j <= ROOTW; j++) begin : g_root
      localparam logic [XW-1:0] TRIAL = XW'(1) << (2 * (ROOTW - j));
      logic [XW-1:0] sum_c;
      logic [XW-1:0] x_ff;
      logic [XW-1:0] r_ff;
      logic          v_st_ff;
      radf_pkg::nvec_type vec_ff;

      assign sum_c = r_q[j-1] + TRIAL;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_st_ff <= 1'b0;
         end else if (adv) begin
            v_st_ff <= val_q[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            vec_ff <= vec_q[j-1];
            if (x_q[j-1] >= sum_c) begin
               x_ff <= x_q[j-1] - sum_c;
               r_ff <= (r_q[j-1] >> 1) + TRIAL;
            end else begin
               x_ff <= x_q[j-1];
               r_ff <= r_q[j-1] >> 1;
            end
         end
      end

      assign x_q[j]   = x_ff;
      assign r_q[j]   = r_ff;
      assign val_q[j] = v_st_ff;
      assign vec_q[j] = vec_ff;
   end

   assign out_valid = val_q[ROOTW];
   assign out_vec   = vec_q[ROOTW];
   assign out_len   = r_q[ROOTW][ROOTW-1:0];

endmodule

[hw/rtl/radf_div.sv]
// Rounded quotient m*2^F/L for three lanes, one quotient bit per stage.
`timescale 1ns / 1ps
module radf_div #(
   parameter int OUT_FRAC_BITS = radf_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  radf_pkg::nvec_type              in_vec,
   input  logic [radf_pkg::ROOTW-1:0]      in_len,
   output logic                            out_valid,
   output logic [2:0][OUT_FRAC_BITS:0]     out_quo,
   output logic [2:0]                      out_neg,
   output radf_pkg::src_type               out_src
);

   localparam int QW = OUT_FRAC_BITS + 1;
   localparam int NUMW = OUT_FRAC_BITS + radf_pkg::NMW + radf_pkg::ROOTW + 4;
   localparam int DENW = radf_pkg::ROOTW + 1;

   logic [NUMW-1:0] num_q [QW+1][3];
   logic [DENW-1:0] den_q [QW+1];
   logic [QW-1:0]   quo_q [QW+1][3];
   logic [2:0]      neg_q [QW+1];
   radf_pkg::src_type src_q [QW+1];
   logic            val_q [QW+1];

   // entry: numerator 2m*2^F + L, denominator 2L, rounds to nearest
   logic [NUMW-1:0] num0_ff [3];
   logic [DENW-1:0] den0_ff;
   logic [2:0]      neg0_ff;
   radf_pkg::src_type src0_ff;
   logic            v0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            num0_ff[k] <= (NUMW'(in_vec.mag[k]) << QW) + NUMW'(in_len);
         end
         den0_ff <= {in_len, 1'b0};
         neg0_ff <= in_vec.neg;
         src0_ff <= in_vec.src;
      end
   end

   assign den_q[0] = den0_ff;
   assign neg_q[0] = neg0_ff;
   assign src_q[0] = src0_ff;
   assign val_q[0] = v0_ff;
   for (genvar k = 0; k < 3; k++) begin : g_init
      assign num_q[0][k] = num0_ff[k];
      assign quo_q[0][k] = '0;
   end

   for (genvar j = 1; j <= QW; j++) begin : g_step
      localparam int SH = QW - j;
      localparam logic [QW-1:0] QBIT = QW'(1) << SH;
      logic [NUMW-1:0] dsh;
      logic [NUMW-1:0] num_ff [3];
      logic [QW-1:0]   quo_ff [3];
      logic [DENW-1:0] den_ff;
      logic [2:0]      neg_ff;
      radf_pkg::src_type src_ff;
      logic            v_ff;

      assign dsh = NUMW'(den_q[j-1]) << SH;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= val_q[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            den_ff <= den_q[j-1];
            neg_ff <= neg_q[j-1];
            src_ff <= src_q[j-1];
            for (int k = 0; k < 3; k++) begin
               if (num_q[j-1][k] >= dsh) begin
                  num_ff[k] <= num_q[j-1][k] - dsh;
                  quo_ff[k] <= quo_q[j-1][k] | QBIT;
               end else begin
                  num_ff[k] <= num_q[j-1][k];
                  quo_ff[k] <= quo_q[j-1][k];
               end
            end
         end
      end

      assign den_q[j] = den_ff;
      assign neg_q[j] = neg_ff;
      assign src_q[j] = src_ff;
      assign val_q[j] = v_ff;
      for (genvar k = 0; k < 3; k++) begin : g_lane
         assign num_q[j][k] = num_ff[k];
         assign quo_q[j][k] = quo_ff[k];
      end
   end

   assign out_valid = val_q[QW];
   assign out_neg   = neg_q[QW];
   assign out_src   = src_q[QW];
   for (genvar k = 0; k < 3; k++) begin : g_out
      assign out_quo[k] = quo_q[QW][k];
   end

endmodule

[hw/rtl/radial_direction_from_axis.sv]
// Top level: unit radial direction of a point from a configured axis line.
`timescale 1ns / 1ps
//
// Use:
//   req carries one point (Q.8 coordinates) with an optional surface normal
//   (Q.12) per beat; rsp returns one beat per request, in order: a Q1.14 unit
//   vector and a source code (radial, normal fallback, or none with zeros).
//   The csr port writes the axis point (indexes 0..2) and axis direction
//   (3..5); write it only while no beat is in flight. Other indexes are dropped.
// From request to response, the front stages form the exact radial vector,
//   the normalization stages normalize it and sum the squares, the square root
//   stages run one root bit per stage, the divider stages run the three dividers
//   one quotient bit per stage, and the output register holds the response.
// Throughput: one beat per cycle while not stalled; all stages advance together.
// Stall: while a response waits and rsp.ready is low, the whole pipeline holds
//   and req.ready drops; nothing is lost or repeated.
// Reset: synchronous, active high; clears all valid bits and sets the axis to
//   origin zero, direction +x.
//
module radial_direction_from_axis #(
   parameter int OUT_FRAC_BITS = radf_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   radf_req_if.sink               req,
   radf_rsp_if.source             rsp,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_index,
   input  logic [radf_pkg::CW-1:0] csr_wr_data
);

   localparam int QW = OUT_FRAC_BITS + 1;

   // configuration registers
   radf_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin <= '0;
         cfg_ff.axis   <= {16'd0, 16'd0, 16'd4096};
      end else if (csr_wr_en) begin
         unique case (csr_index)
            radf_pkg::CSR_ORIGIN_X: cfg_ff.origin[0] <= csr_wr_data;
            radf_pkg::CSR_ORIGIN_Y: cfg_ff.origin[1] <= csr_wr_data;
            radf_pkg::CSR_ORIGIN_Z: cfg_ff.origin[2] <= csr_wr_data;
            radf_pkg::CSR_AXIS_X:   cfg_ff.axis[0]   <= csr_wr_data[radf_pkg::NW-1:0];
            radf_pkg::CSR_AXIS_Y:   cfg_ff.axis[1]   <= csr_wr_data[radf_pkg::NW-1:0];
            radf_pkg::CSR_AXIS_Z:   cfg_ff.axis[2]   <= csr_wr_data[radf_pkg::NW-1:0];
            default: ;
         endcase
      end
   end

   // advance whenever the output register is free or being drained
   logic out_v_ff;
   logic adv;

   assign adv       = !out_v_ff || rsp.ready;
   assign req.ready = adv;

   radf_pkg::item_type item;

   assign item.pt  = {req.point_z, req.point_y, req.point_x};
   assign item.nrm = {req.surf_normal_z, req.surf_normal_y, req.surf_normal_x};
   assign item.np  = req.normal_present;

   logic               fr_v;
   radf_pkg::vsel_type fr_vec;
   logic               nm_v;
   radf_pkg::nvec_type nm_vec;
   logic [radf_pkg::ROOTW-1:0] nm_len;
   logic               dv_v;
   logic [2:0][QW-1:0] dv_quo;
   logic [2:0]         dv_neg;
   radf_pkg::src_type  dv_src;

   radf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req.valid),
      .in_item   (item),
      .cfg       (cfg_ff),
      .out_valid (fr_v),
      .out_vec   (fr_vec)
   );

   radf_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_v),
      .in_vec    (fr_vec),
      .out_valid (nm_v),
      .out_vec   (nm_vec),
      .out_len   (nm_len)
   );

   radf_div #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (nm_v),
      .in_vec    (nm_vec),
      .in_len    (nm_len),
      .out_valid (dv_v),
      .out_quo   (dv_quo),
      .out_neg   (dv_neg),
      .out_src   (dv_src)
   );

   // output register: apply signs, zero the failure case
   logic [QW+radf_pkg::DW-1:0] qz [3];
   logic [QW+radf_pkg::DW-1:0] qs [3];
   logic [radf_pkg::DW-1:0]    dir_in [3];
   logic [radf_pkg::DW-1:0]    dir_ff [3];
   radf_pkg::src_type          src_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         qz[k]     = (QW + radf_pkg::DW)'(dv_quo[k]);
         qs[k]     = dv_neg[k] ? -qz[k] : qz[k];
         dir_in[k] = (dv_src == radf_pkg::SRC_NONE) ? '0 : qs[k][radf_pkg::DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            dir_ff[k] <= dir_in[k];
         end
         src_ff <= dv_src;
      end
   end

   assign rsp.valid      = out_v_ff;
   assign rsp.dir_x      = dir_ff[0];
   assign rsp.dir_y      = dir_ff[1];
   assign rsp.dir_z      = dir_ff[2];
   assign rsp.dir_source = src_ff;

endmodule

[hw/rtl/radf_chk.sv]
// Port-level checker for the radial direction block, with its bind.
`timescale 1ns / 1ps
module radf_chk (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [radf_pkg::DW-1:0] dir_x,
   input logic [radf_pkg::DW-1:0] dir_y,
   input logic [radf_pkg::DW-1:0] dir_z,
   input logic [1:0]              dir_source
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(dir_x) && $stable(dir_y)
                                  && $stable(dir_z) && $stable(dir_source))
      else $error("stalled response changed");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dir_source == radf_pkg::SRC_NONE |->
         dir_x == '0 && dir_y == '0 && dir_z == '0)
      else $error("failure response carries a nonzero vector");

   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dir_source != radf_pkg::SRC_NONE |->
         dir_x != '0 || dir_y != '0 || dir_z != '0)
      else $error("successful response carries a zero vector");

endmodule

bind radial_direction_from_axis radf_chk u_radf_chk (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .dir_x      (rsp.dir_x),
   .dir_y      (rsp.dir_y),
   .dir_z      (rsp.dir_z),
   .dir_source (rsp.dir_source)
);

[test/tb.sv]
// Self-checking testbench for the radial direction block.
`timescale 1ns / 1ps

import radf_pkg::*;

// One result beat: Q1.14 direction and where it came from.
typedef struct {
   logic signed [DW-1:0] x;
   logic signed [DW-1:0] y;
   logic signed [DW-1:0] z;
   src_type              src;
} dir_beat_t;

// Holds the axis setting, predicts each direction and checks the replies in order.
class radial_scoreboard;
   longint    origin[3];
   longint    axis[3];
   dir_beat_t pending_dirs[$];
   int        mismatches;

   function new();
      origin = '{0, 0, 0};
      axis = '{4096, 0, 0};
      mismatches = 0;
   endfunction

   // Mirror a register write; unknown indexes are dropped like in the block.
   function void write_reg(logic [2:0] idx, logic [CW-1:0] data);
      case (idx)
         CSR_ORIGIN_X: origin[0] = longint'($signed(data));
         CSR_ORIGIN_Y: origin[1] = longint'($signed(data));
         CSR_ORIGIN_Z: origin[2] = longint'($signed(data));
         CSR_AXIS_X:   axis[0] = longint'($signed(data[NW-1:0]));
         CSR_AXIS_Y:   axis[1] = longint'($signed(data[NW-1:0]));
         CSR_AXIS_Z:   axis[2] = longint'($signed(data[NW-1:0]));
         default: ;
      endcase
   endfunction

   static function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Scale a vector to unit length in Q1.14; returns 0 for a zero vector.
   static function bit to_unit(longint v[3], output logic signed [DW-1:0] o[3]);
      longint unsigned m[3], mx, s, l, q;
      bit              neg[3];
      mx = 0;
      for (int k = 0; k < 3; k++) begin
         neg[k] = v[k] < 0;
         m[k] = neg[k] ? -v[k] : v[k];
         if (m[k] > mx) mx = m[k];
      end
      o = '{0, 0, 0};
      if (mx == 0) return 0;
      while (mx >= (64'd1 << 30)) begin
         for (int k = 0; k < 3; k++) m[k] >>= 1;
         mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         for (int k = 0; k < 3; k++) m[k] <<= 1;
         mx <<= 1;
      end
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      l = int_sqrt(s);
      for (int k = 0; k < 3; k++) begin
         q = ((m[k] << (OUT_FRAC_BITS_DEF + 1)) + l) / (2 * l);
         o[k] = neg[k] ? -DW'(q) : DW'(q);
      end
      return 1;
   endfunction

   // Note an accepted request and queue the direction it must produce.
   function void note_point(item_type it);
      longint               a[3], d[3], r[3], n[3];
      longint               a2, dot;
      longint unsigned      n2;
      logic signed [DW-1:0] o[3];
      dir_beat_t            e;
      a = axis;
      a2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      if (a2 == 0) begin
         a = '{1, 0, 0};
         a2 = 1;
      end
      for (int k = 0; k < 3; k++) d[k] = longint'($signed(it.pt[k])) - origin[k];
      dot = d[0] * a[0] + d[1] * a[1] + d[2] * a[2];
      for (int k = 0; k < 3; k++) r[k] = d[k] * a2 - dot * a[k];
      e.src = SRC_NONE;
      if (to_unit(r, o)) begin
         e.src = SRC_RADIAL;
      end else if (it.np) begin
         n2 = 0;
         for (int k = 0; k < 3; k++) begin
            n[k] = longint'($signed(it.nrm[k]));
            n2 += n[k] * n[k];
         end
         if (n2 > NRM_MIN_SQ && to_unit(n, o)) e.src = SRC_NORMAL;
      end
      if (e.src == SRC_NONE) o = '{0, 0, 0};
      e.x = o[0];
      e.y = o[1];
      e.z = o[2];
      pending_dirs.push_back(e);
   endfunction

   function void check_dir(dir_beat_t got);
      dir_beat_t e;
      if (pending_dirs.size() == 0) begin
         $display("%0t: unexpected beat x=%0d y=%0d z=%0d src=%0d", $time, got.x, got.y,
                  got.z, got.src);
         mismatches++;
         return;
      end
      e = pending_dirs.pop_front();
      if (got.x !== e.x) begin
         $display("%0t: dir_x expected %0d actual %0d", $time, e.x, got.x);
         mismatches++;
      end
      if (got.y !== e.y) begin
         $display("%0t: dir_y expected %0d actual %0d", $time, e.y, got.y);
         mismatches++;
      end
      if (got.z !== e.z) begin
         $display("%0t: dir_z expected %0d actual %0d", $time, e.z, got.z);
         mismatches++;
      end
      if (got.src !== e.src) begin
         $display("%0t: dir_source expected %0d actual %0d", $time, e.src, got.src);
         mismatches++;
      end
   endfunction
endclass

module tb;
   localparam int          LATENCY = 44 + OUT_FRAC_BITS_DEF;
   localparam int          SETTLE = LATENCY + 20;
   localparam int          STALL_LIMIT = 3000;   // cycles with no beat and no write
   localparam int          LONG_HOLD = 400;      // receiver hold-off, fills the pipeline
   localparam logic [2:0]  CSR_SPARE_LO = 3'd6;  // unmapped indexes, must be dropped
   localparam logic [2:0]  CSR_SPARE_HI = 3'd7;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [2:0]       csr_index;
   logic [CW-1:0]    csr_wr_data;

   radf_req_if req_if ();
   radf_rsp_if rsp_if ();

   radial_direction_from_axis DUT (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   radial_scoreboard dirs_sb = new();

   bit no_gaps;           // burst phase: neither side idles
   int dirs_received;
   int idle_cycles;

   // 20 ns clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Check every response beat; values read here are the pre-edge ones.
   always @(posedge clock) begin
      dir_beat_t got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.x = rsp_if.dir_x;
         got.y = rsp_if.dir_y;
         got.z = rsp_if.dir_z;
         got.src = src_type'(rsp_if.dir_source);
         dirs_sb.check_dir(got);
         dirs_received++;
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Receiver: random stalls, one long hold-off once traffic is flowing.
   initial begin
      int  stall;
      bit  held;
      held = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && dirs_received >= 200) begin
            held = 1;
            stall = LONG_HOLD;
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Write one register; hold the enable for the next write in the batch.
   task automatic write_reg(logic [2:0] idx, logic [CW-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      dirs_sb.write_reg(idx, data);
   endtask

   // Load a full axis setting, plus junk writes to the unmapped indexes.
   task automatic load_axis(logic [CW-1:0] ox, logic [CW-1:0] oy, logic [CW-1:0] oz,
                            logic [NW-1:0] ax, logic [NW-1:0] ay, logic [NW-1:0] az);
      write_reg(CSR_SPARE_LO, CW'($urandom));
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_ORIGIN_Z, oz);
      write_reg(CSR_AXIS_X, {{(CW-NW){ax[NW-1]}}, ax});
      write_reg(CSR_AXIS_Y, {{(CW-NW){ay[NW-1]}}, ay});
      write_reg(CSR_AXIS_Z, {{(CW-NW){az[NW-1]}}, az});
      write_reg(CSR_SPARE_HI, CW'($urandom));
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one beat, wait for the handshake, then idle for the drawn gap.
   task automatic send_point(item_type it);
      int gap;
      req_if.valid <= 1'b1;
      req_if.point_x <= it.pt[0];
      req_if.point_y <= it.pt[1];
      req_if.point_z <= it.pt[2];
      req_if.surf_normal_x <= it.nrm[0];
      req_if.surf_normal_y <= it.nrm[1];
      req_if.surf_normal_z <= it.nrm[2];
      req_if.normal_present <= it.np;
      do @(posedge clock); while (!req_if.ready);
      dirs_sb.note_point(it);
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every direction is back, then let the pipe drain.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (dirs_sb.pending_dirs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic item_type mk(longint px, longint py, longint pz,
                                   longint nx, longint ny, longint nz, bit np);
      item_type it;
      it.pt[0] = CW'(px);
      it.pt[1] = CW'(py);
      it.pt[2] = CW'(pz);
      it.nrm[0] = NW'(nx);
      it.nrm[1] = NW'(ny);
      it.nrm[2] = NW'(nz);
      it.np = np;
      return it;
   endfunction

   // Random beat: mostly points on or next to the axis, the rest anywhere.
   function automatic item_type rand_point();
      item_type it;
      longint   k;
      int       pick;
      pick = $urandom_range(0, 99);
      it.pt[0] = CW'($urandom);
      it.pt[1] = CW'($urandom);
      it.pt[2] = CW'($urandom);
      it.nrm[0] = NW'($urandom);
      it.nrm[1] = NW'($urandom);
      it.nrm[2] = NW'($urandom);
      it.np = $urandom_range(0, 3) != 0;
      if (pick < 50) begin
         k = longint'($urandom_range(0, 200)) - 100;
         for (int i = 0; i < 3; i++)
            it.pt[i] = CW'(dirs_sb.origin[i] + k * dirs_sb.axis[i]);
         // zero axis acts as +x
         if (dirs_sb.axis[0] == 0 && dirs_sb.axis[1] == 0 && dirs_sb.axis[2] == 0)
            it.pt[0] = CW'(dirs_sb.origin[0] + k);
         if (pick < 15) begin
            // short normals around the 0.5 threshold
            it.nrm[0] = NW'(longint'($urandom_range(0, 4200)) - 2100);
            it.nrm[1] = NW'(longint'($urandom_range(0, 600)) - 300);
            it.nrm[2] = NW'(longint'($urandom_range(0, 600)) - 300);
         end
      end else if (pick < 65) begin
         for (int i = 0; i < 3; i++)
            it.pt[i] = CW'(dirs_sb.origin[i] + longint'($urandom_range(0, 4)) - 2);
      end
      return it;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) send_point(rand_point());
      drain();
   endtask

   initial begin
      no_gaps = 0;
      dirs_received = 0;
      idle_cycles = 0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_ORIGIN_X;
      csr_wr_data <= '0;
      req_if.valid <= 1'b0;
      req_if.point_x <= '0;
      req_if.point_y <= '0;
      req_if.point_z <= '0;
      req_if.surf_normal_x <= '0;
      req_if.surf_normal_y <= '0;
      req_if.surf_normal_z <= '0;
      req_if.normal_present <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats on the reset axis (origin zero, direction +x).
      send_point(mk(1280, 256, 0, 0, 0, 0, 0));              // plain radial
      send_point(mk(5, 0, 0, 4096, 0, 0, 1));                // on axis, unit normal
      send_point(mk(0, 0, 0, 2048, 0, 0, 1));                // normal exactly 0.5: fail
      send_point(mk(-7, 0, 0, 2049, 0, 0, 1));               // normal just above 0.5
      send_point(mk(9, 0, 0, 4096, 4096, 0, 0));             // normal ignored: fail
      send_point(mk(0, 0, 0, -32768, -32768, -32768, 1));    // most negative normal
      send_point(mk(0, 0, 0, 32767, 0, -32768, 1));
      send_point(mk(8388607, 8388607, 8388607, 0, 0, 0, 1));
      send_point(mk(-8388608, -8388608, -8388608, 0, 0, 0, 0));
      send_point(mk(0, 8388607, -8388608, 0, 0, 0, 0));
      send_point(mk(100, -1, 1, 0, 0, 0, 0));                // smallest radial
      send_point(mk(3, 0, 0, 0, 0, 0, 1));                   // zero normal present: fail
      drain();

      // Zero axis falls back to +x; extreme origin.
      load_axis(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h0000, 16'h0000, 16'h0000);
      send_point(mk(8388607, -8388608, 8388607, 0, 4096, 0, 1));
      send_point(mk(-8388608, 8388607, -8388608, 0, 0, 0, 0));
      send_point(mk(0, -8388608, 8388607, 100, 100, 100, 1));
      drain();

      // Extreme axis components and origin.
      load_axis(24'h800000, 24'h7FFFFF, 24'h800000, 16'h8000, 16'h8000, 16'h8000);
      send_point(mk(8388607, -8388608, 8388607, 0, 0, 0, 0));
      send_point(mk(-8388608, 8388607, -8388608, 0, 0, 0, 0));
      send_point(mk(-8388608, 8388607, -8388608, 0, 0, 0, 0));
      drain();
      load_axis(0, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF);
      send_point(mk(8388607, 8388607, -8388608, 0, 0, 0, 0));
      send_point(mk(1, 1, 1, 0, 0, 0, 0));
      drain();

      // Random phases; the sender pauses for all results at each boundary.
      load_axis(0, 0, 0, 16'd4096, 0, 0);
      random_phase(150);
      no_gaps = 1;
      random_phase(120);
      no_gaps = 0;
      load_axis(24'h7FFFFF, 24'h800000, 24'h000001, 16'h8000, 16'h7FFF, 16'h8000);
      random_phase(140);
      load_axis(0, 0, 0, 0, 0, 0);
      random_phase(100);
      for (int p = 0; p < 3; p++) begin
         load_axis(CW'($urandom), CW'($urandom), CW'($urandom),
                   NW'($urandom), NW'($urandom), NW'($urandom));
         no_gaps = (p == 1);
         random_phase(110);
      end
      no_gaps = 0;

      if (dirs_sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

[filelist.f]
hw/rtl/radf_pkg.sv
hw/rtl/radf_if.sv
hw/rtl/radf_front.sv
hw/rtl/radf_norm.sv
hw/rtl/radf_div.sv
hw/rtl/radial_direction_from_axis.sv
hw/rtl/radf_chk.sv
test/tb.sv
